// ===== sv/lmtw_pkg.sv =====
// Shared types and constants for the two-wire LED matrix writer.
`default_nettype none
package lmtw_pkg;

	localparam int unsigned CMD_W   = 8;
	localparam int unsigned HOLD_W  = 10;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned SEG_W   = 8;
	localparam int unsigned FRAME_W = 2 * SEG_W;
	localparam int unsigned BITCNT_W = $clog2(FRAME_W);

	localparam logic [CMD_W-1:0]  ADDRESS_BASE      = 8'hC0;
	localparam logic [CMD_W-1:0]  DISPLAY_ON_RESET  = 8'd143;
	localparam logic [HOLD_W-1:0] SETTLE_RESET      = 10'd50;
	localparam logic [HOLD_W-1:0] HOLD_ONE_UNIT     = 10'd1;
	localparam logic [HOLD_W-1:0] HOLD_TWO_UNITS    = 10'd2;
	localparam logic [HOLD_W-1:0] HOLD_NONE         = 10'd0;

	localparam logic OP_DISPLAY_ON    = 1'b0;
	localparam logic OP_SEGMENT_WRITE = 1'b1;

	localparam logic REG_DISPLAY_ON_COMMAND = 1'b0;
	localparam logic REG_SETTLE_UNITS       = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START0,
		ST_START1,
		ST_BIT_SET,
		ST_BIT_HIGH,
		ST_BIT_LOW,
		ST_STOP0,
		ST_STOP1,
		ST_STOP2
	} state_t;

	typedef enum logic [1:0] {
		DAT_LOW,
		DAT_HIGH,
		DAT_BIT
	} dat_sel_t;

	typedef enum logic [1:0] {
		HOLD_SEL_ONE,
		HOLD_SEL_TWO,
		HOLD_SEL_FINAL
	} hold_sel_t;

	typedef struct packed {
		logic      load;
		logic      emit;
		logic      shift;
		logic      clk_level;
		dat_sel_t  dat_sel;
		hold_sel_t hold_sel;
		logic      last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic bit_last;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/lmtw_ctrl.sv =====
// Frame sequencer state machine for the two-wire LED matrix writer.
`default_nettype none
module lmtw_ctrl
	import lmtw_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.emit     = 1'b0;
		cmd.shift    = 1'b0;
		cmd.clk_level = 1'b0;
		cmd.dat_sel  = DAT_LOW;
		cmd.hold_sel = HOLD_SEL_ONE;
		cmd.last     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START0;
				end
			end
			ST_START0: begin
				cmd.clk_level = 1'b1;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_START1;
				end
			end
			ST_START1: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_BIT_SET;
				end
			end
			ST_BIT_SET: begin
				cmd.dat_sel = DAT_BIT;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_BIT_HIGH;
				end
			end
			ST_BIT_HIGH: begin
				cmd.clk_level = 1'b1;
				cmd.dat_sel   = DAT_BIT;
				cmd.hold_sel  = HOLD_SEL_TWO;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_BIT_LOW;
				end
			end
			ST_BIT_LOW: begin
				cmd.dat_sel = DAT_BIT;
				if (status.out_free) begin
					cmd.emit  = 1'b1;
					cmd.shift = 1'b1;
					state_d   = status.bit_last ? ST_STOP0 : ST_BIT_SET;
				end
			end
			ST_STOP0: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_STOP1;
				end
			end
			ST_STOP1: begin
				cmd.clk_level = 1'b1;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_STOP2;
				end
			end
			ST_STOP2: begin
				cmd.clk_level = 1'b1;
				cmd.dat_sel   = DAT_HIGH;
				cmd.hold_sel  = HOLD_SEL_FINAL;
				cmd.last      = 1'b1;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/lmtw_datapath.sv =====
// Shift register, bit counter, configuration registers and output register.
`default_nettype none
module lmtw_datapath
	import lmtw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [HOLD_W-1:0] cfg_data,
	input  wire logic              in_operation,
	input  wire logic [POS_W-1:0]  in_position,
	input  wire logic [SEG_W-1:0]  in_segments,
	input  wire cmd_t              cmd,
	output status_t                status,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_clock_level,
	output logic                   out_data_level,
	output logic [HOLD_W-1:0]      out_hold_units,
	output logic                   out_last_change
);

	logic [CMD_W-1:0]    display_on_q;
	logic [HOLD_W-1:0]   settle_q;
	logic [FRAME_W-1:0]  shift_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic [BITCNT_W-1:0] bit_last_idx_q;
	logic [HOLD_W-1:0]   final_hold_q;
	logic                valid_q;
	logic                clock_q;
	logic                data_q;
	logic [HOLD_W-1:0]   hold_q;
	logic                last_q;
	logic [CMD_W-1:0]    address_byte;
	logic                data_next;
	logic [HOLD_W-1:0]   hold_next;

	assign address_byte = ADDRESS_BASE + {{(CMD_W-POS_W){1'b0}}, in_position};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_on_q <= DISPLAY_ON_RESET;
			settle_q     <= SETTLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DISPLAY_ON_COMMAND: display_on_q <= cfg_data[CMD_W-1:0];
				REG_SETTLE_UNITS:       settle_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bit_cnt_q <= '0;
			if (in_operation == OP_SEGMENT_WRITE) begin
				shift_q        <= {in_segments, address_byte};
				bit_last_idx_q <= BITCNT_W'(FRAME_W - 1);
				final_hold_q   <= HOLD_NONE;
			end else begin
				shift_q        <= {{(FRAME_W-CMD_W){1'b0}}, display_on_q};
				bit_last_idx_q <= BITCNT_W'(CMD_W - 1);
				final_hold_q   <= settle_q;
			end
		end else if (cmd.shift) begin
			shift_q   <= shift_q >> 1;
			bit_cnt_q <= bit_cnt_q + 1'b1;
		end
	end

	always_comb begin
		case (cmd.dat_sel)
			DAT_LOW:  data_next = 1'b0;
			DAT_HIGH: data_next = 1'b1;
			DAT_BIT:  data_next = shift_q[0];
			default:  data_next = 1'b0;
		endcase
		case (cmd.hold_sel)
			HOLD_SEL_ONE:   hold_next = HOLD_ONE_UNIT;
			HOLD_SEL_TWO:   hold_next = HOLD_TWO_UNITS;
			HOLD_SEL_FINAL: hold_next = final_hold_q;
			default:        hold_next = HOLD_ONE_UNIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			clock_q <= cmd.clk_level;
			data_q  <= data_next;
			hold_q  <= hold_next;
			last_q  <= cmd.last;
		end
	end

	assign status.out_free = !valid_q || out_ready;
	assign status.bit_last = (bit_cnt_q == bit_last_idx_q);

	assign out_valid       = valid_q;
	assign out_clock_level = clock_q;
	assign out_data_level  = data_q;
	assign out_hold_units  = hold_q;
	assign out_last_change = last_q;

endmodule
`default_nettype wire

// ===== sv/led_matrix_two_wire_writer.sv =====
// Top level of the two-wire LED matrix writer: pin change sequencer for one frame per item.
//
// The slave stream takes one frame request per transaction: s_tuser selects the
// operation (display-on command or segment write), s_tdata carries the grid
// position and the segment byte. The master stream delivers one pin change per
// transaction: clock level, data level and hold time in base units, with m_tlast
// on the final change of the frame.
// A segment write produces 53 changes, a display-on command 29. After the request
// is accepted, the sequencer leaves idle and the first change is registered into the
// output register. With the receiver always ready, the sequencer emits one change per
// cycle set by the frame state machine, and then returns to idle to take the next request.
// Only one frame is in flight at a time. When the receiver stalls, the output register
// holds its change and the sequencer waits; no change is lost or repeated.
// The configuration port writes the display-on command byte (index 0) and the
// settle hold (index 1); write them only while no frame is in flight.
// Reset clears the sequencer and the output valid flag and restores the
// configuration registers to 0x8F and 50.
`default_nettype none
module led_matrix_two_wire_writer
	import lmtw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [HOLD_W-1:0] cfg_data,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [15:0]       s_tdata,  // position[3:0], segments[11:4], zero[15:12]
	input  wire logic              s_tuser,  // operation[0]
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [15:0]            m_tdata,  // clock_level[0], data_level[1], hold_units[11:2]
	output logic                   m_tlast
);

	cmd_t              cmd;
	status_t           status;
	logic              clock_level;
	logic              data_level;
	logic [HOLD_W-1:0] hold_units;

	lmtw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lmtw_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_operation    (s_tuser),
		.in_position     (s_tdata[POS_W-1:0]),
		.in_segments     (s_tdata[POS_W+SEG_W-1:POS_W]),
		.cmd             (cmd),
		.status          (status),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_clock_level (clock_level),
		.out_data_level  (data_level),
		.out_hold_units  (hold_units),
		.out_last_change (m_tlast)
	);

	assign m_tdata = {4'b0000, hold_units, data_level, clock_level};

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the two-wire LED matrix writer with a pin change predictor.
module tb;
	import lmtw_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic             op;
		logic [POS_W-1:0] pos;
		logic [SEG_W-1:0] seg;
	} frame_req_t;

	typedef struct packed {
		logic              clk_lvl;
		logic              dat_lvl;
		logic [HOLD_W-1:0] hold;
		logic              last;
	} pin_change_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [HOLD_W-1:0] cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;
	logic              m_tlast;

	frame_req_t  frame_q[$];
	pin_change_t pin_q[$];
	frame_req_t  frame_on_bus;

	logic [CMD_W-1:0]  display_cmd = DISPLAY_ON_RESET;
	logic [HOLD_W-1:0] settle_hold = SETTLE_RESET;

	bit          bursty = 1'b0;
	bit          s_took = 1'b0;
	int unsigned s_gap = 0;
	int unsigned m_gap = 0;
	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned n_display = 0;
	int unsigned n_write = 0;
	int unsigned n_changes = 0;
	int unsigned n_settings = 1;

	led_matrix_two_wire_writer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic void add_change(input logic c, input logic d,
			input logic [HOLD_W-1:0] h, input logic l);
		pin_change_t p;
		p.clk_lvl = c;
		p.dat_lvl = d;
		p.hold = h;
		p.last = l;
		pin_q.push_back(p);
	endfunction

	function automatic void expect_frame(input frame_req_t r);
		logic [CMD_W-1:0] frame_bytes[2];
		int               n_bytes;
		logic             b;
		add_change(1'b1, 1'b0, HOLD_ONE_UNIT, 1'b0);
		add_change(1'b0, 1'b0, HOLD_ONE_UNIT, 1'b0);
		if (r.op == OP_DISPLAY_ON) begin
			frame_bytes[0] = display_cmd;
			n_bytes = 1;
		end else begin
			frame_bytes[0] = ADDRESS_BASE + {{(CMD_W-POS_W){1'b0}}, r.pos};
			frame_bytes[1] = r.seg;
			n_bytes = 2;
		end
		for (int k = 0; k < n_bytes; k++) begin
			for (int i = 0; i < 8; i++) begin
				b = frame_bytes[k][i];
				add_change(1'b0, b, HOLD_ONE_UNIT, 1'b0);
				add_change(1'b1, b, HOLD_TWO_UNITS, 1'b0);
				add_change(1'b0, b, HOLD_ONE_UNIT, 1'b0);
			end
		end
		add_change(1'b0, 1'b0, HOLD_ONE_UNIT, 1'b0);
		add_change(1'b1, 1'b0, HOLD_ONE_UNIT, 1'b0);
		add_change(1'b1, 1'b1, (r.op == OP_DISPLAY_ON) ? settle_hold : HOLD_NONE, 1'b1);
	endfunction

	// Request driver.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_took) begin
				if (s_gap > 0) begin
					s_gap--;
					s_tvalid <= 1'b0;
				end else if (frame_q.size() > 0) begin
					frame_on_bus = frame_q.pop_front();
					s_tdata <= {4'b0, frame_on_bus.seg, frame_on_bus.pos};
					s_tuser <= frame_on_bus.op;
					s_tvalid <= 1'b1;
					if (bursty && $urandom_range(0, 2) == 0)
						s_gap = $urandom_range(1, 7);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall generator.
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_gap > 0) begin
				m_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (bursty && $urandom_range(0, 9) == 0)
					m_gap = $urandom_range(1, 7);
			end
		end
	end

	// Acceptance tracking and pin change checking.
	always @(posedge clk) begin
		pin_change_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d pin changes pending.",
				cycles, pin_q.size());
			$display("CHECK FAILED");
			$finish;
		end else if (arst_n) begin
			s_took <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				expect_frame(frame_on_bus);
				if (frame_on_bus.op == OP_DISPLAY_ON)
					n_display++;
				else
					n_write++;
			end
			if (m_tvalid && m_tready) begin
				if (pin_q.size() == 0) begin
					$error("unexpected pin change transaction: tdata %h, tlast %0d",
						m_tdata, m_tlast);
					errors++;
				end else begin
					want = pin_q.pop_front();
					n_changes++;
					if (m_tdata[0] !== want.clk_lvl) begin
						$error("clock_level: expected %0d, got %0d", want.clk_lvl, m_tdata[0]);
						errors++;
					end
					if (m_tdata[1] !== want.dat_lvl) begin
						$error("data_level: expected %0d, got %0d", want.dat_lvl, m_tdata[1]);
						errors++;
					end
					if (m_tdata[11:2] !== want.hold) begin
						$error("hold_units: expected %0d, got %0d", want.hold, m_tdata[11:2]);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last_change: expected %0d, got %0d", want.last, m_tlast);
						errors++;
					end
				end
			end
		end
	end

	task automatic push_frame(input logic op, input int pos, input int seg);
		frame_req_t r;
		r.op = op;
		r.pos = pos[POS_W-1:0];
		r.seg = seg[SEG_W-1:0];
		frame_q.push_back(r);
	endtask

	task automatic drain;
		wait (frame_q.size() == 0 && !s_tvalid && pin_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_registers(input int cmd, input int settle);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_DISPLAY_ON_COMMAND;
		cfg_data <= HOLD_W'(cmd);
		display_cmd = CMD_W'(cmd);
		@(negedge clk);
		cfg_index <= REG_SETTLE_UNITS;
		cfg_data <= HOLD_W'(settle);
		settle_hold = HOLD_W'(settle);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic random_frames(input int n);
		for (int i = 0; i < n; i++)
			push_frame(1'($urandom_range(0, 1)), $urandom_range(0, 15),
				$urandom_range(0, 255));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_frame(OP_DISPLAY_ON, 0, 0);
		push_frame(OP_SEGMENT_WRITE, 0, 8'h00);
		push_frame(OP_SEGMENT_WRITE, 15, 8'hFF);
		push_frame(OP_SEGMENT_WRITE, 5, 8'hA5);
		push_frame(OP_SEGMENT_WRITE, 10, 8'h5A);
		push_frame(OP_SEGMENT_WRITE, 1, 8'h01);
		push_frame(OP_SEGMENT_WRITE, 14, 8'h80);
		push_frame(OP_DISPLAY_ON, 15, 255);
		drain();

		bursty = 1'b1;
		set_registers(0, 0);
		push_frame(OP_DISPLAY_ON, 3, 7);
		push_frame(OP_SEGMENT_WRITE, 7, 8'h0F);
		push_frame(OP_DISPLAY_ON, 8, 200);
		drain();

		set_registers(255, 1023);
		push_frame(OP_DISPLAY_ON, 0, 0);
		push_frame(OP_SEGMENT_WRITE, 8, 8'hF0);
		push_frame(OP_DISPLAY_ON, 12, 99);
		drain();

		set_registers(143, 50);
		random_frames(55);
		drain();

		bursty = 1'b0;
		set_registers($urandom_range(0, 255), $urandom_range(0, 1023));
		random_frames(55);
		drain();

		bursty = 1'b1;
		set_registers($urandom_range(0, 255), 1);
		random_frames(55);
		drain();

		set_registers($urandom_range(0, 255), $urandom_range(0, 1023));
		random_frames(55);
		drain();

		bursty = 1'b0;
		set_registers(8'hA5, $urandom_range(0, 1023));
		random_frames(50);
		drain();

		if (pin_q.size() != 0) begin
			$error("%0d expected pin changes never arrived", pin_q.size());
			errors++;
		end
		$display("Sent %0d display-on frames and %0d segment writes; checked %0d pin changes.",
			n_display, n_write, n_changes);
		$display("Register settings used: %0d, including both command and settle extremes.",
			n_settings);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== led_matrix_two_wire_writer.f =====
sv/lmtw_pkg.sv
sv/lmtw_ctrl.sv
sv/lmtw_datapath.sv
sv/led_matrix_two_wire_writer.sv
sim/tb.sv
